[rtl/core/assert_macros.svh]
// Assertion macros shared by the checker modules of this core.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mlr_pkg.sv]
// Shared types and constants for the midpoint line rasterizer core.
// No dependencies; used by the walker, the top level and the checker.
package mlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 24;
  // Delta between two points, and the scaled decision variable.
  localparam int DLT_BITS   = COORD_BITS + 1;
  localparam int DEC_BITS   = COORD_BITS + 4;

  localparam logic [COLOR_BITS-1:0] PEN_COLOR_RST = '1;

  localparam logic [1:0] KIND_MOVE = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_STEP = 2'd2;

  localparam logic [1:0] SLOPE_SHALLOW_UP = 2'd0;
  localparam logic [1:0] SLOPE_SHALLOW_DN = 2'd1;
  localparam logic [1:0] SLOPE_STEEP_UP   = 2'd2;
  localparam logic [1:0] SLOPE_STEEP_DN   = 2'd3;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } mlr_in_t;

  typedef struct packed {
    logic                         pixel_valid;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         last_pixel;
    logic                         busy_reject;
  } mlr_out_t;

endpackage

[rtl/core/mlr_walker.sv]
// Line state and per-transaction datapath: move, line setup and pixel step.
// Depends on mlr_pkg; the result is combinational, state updates on fire.
module mlr_walker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  mlr_pkg::mlr_in_t               item,
  input  logic [mlr_pkg::COLOR_BITS-1:0] pen_color,
  output mlr_pkg::mlr_out_t              result
);

  localparam int CB = mlr_pkg::COORD_BITS;
  localparam int DB = mlr_pkg::DLT_BITS;
  localparam int EB = mlr_pkg::DEC_BITS;

  logic signed [CB-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [CB-1:0] walk_x_r, walk_x_nxt, walk_y_r, walk_y_nxt;
  logic signed [CB-1:0] stop_major_r, stop_major_nxt;
  logic signed [EB-1:0] decision_r, decision_nxt;
  logic signed [EB-1:0] inc_take_r, inc_take_nxt, inc_keep_r, inc_keep_nxt;
  logic [1:0]           slope_class_r, slope_class_nxt;
  logic                 line_active_r, line_active_nxt;

  // Step datapath
  logic                 take;
  logic signed [CB-1:0] step_x, step_y;
  logic                 step_done;
  logic signed [EB-1:0] step_dec;

  always_comb begin
    take      = 1'b0;
    step_x    = walk_x_r;
    step_y    = walk_y_r;
    step_done = 1'b0;
    unique case (slope_class_r)
      mlr_pkg::SLOPE_SHALLOW_UP: begin
        take      = decision_r < 0;
        step_y    = take ? walk_y_r + CB'(1) : walk_y_r;
        step_x    = walk_x_r + CB'(1);
        step_done = step_x >= stop_major_r;
      end
      mlr_pkg::SLOPE_SHALLOW_DN: begin
        take      = decision_r > 0;
        step_y    = take ? walk_y_r - CB'(1) : walk_y_r;
        step_x    = walk_x_r + CB'(1);
        step_done = step_x >= stop_major_r;
      end
      mlr_pkg::SLOPE_STEEP_UP: begin
        take      = decision_r >= 0;
        step_x    = take ? walk_x_r + CB'(1) : walk_x_r;
        step_y    = walk_y_r + CB'(1);
        step_done = step_y >= stop_major_r;
      end
      mlr_pkg::SLOPE_STEEP_DN: begin
        take      = decision_r < 0;
        step_x    = take ? walk_x_r + CB'(1) : walk_x_r;
        step_y    = walk_y_r - CB'(1);
        step_done = step_y <= stop_major_r;
      end
      default: ;
    endcase
    step_dec = decision_r + (take ? inc_take_r : inc_keep_r);
  end

  // Line setup datapath
  logic signed [DB-1:0] dx0, dy0;
  logic [DB-1:0]        adx, ady;
  logic                 zero_len, steep, swap;
  logic [1:0]           cls;
  logic signed [EB-1:0] dxe, dye, dx, dy;
  logic signed [EB-1:0] dec0, take0, keep0;
  logic signed [CB-1:0] start_x, start_y, stop0;

  assign dx0      = DB'(item.point_x) - DB'(cur_x_r);
  assign dy0      = DB'(item.point_y) - DB'(cur_y_r);
  assign adx      = dx0 < 0 ? DB'(-dx0) : DB'(dx0);
  assign ady      = dy0 < 0 ? DB'(-dy0) : DB'(dy0);
  assign zero_len = (dx0 == '0) && (dy0 == '0);
  assign steep    = ady > adx;

  always_comb begin
    if (dx0 == '0) begin
      cls = mlr_pkg::SLOPE_STEEP_UP;
    end else if (dy0 == '0 || ((dx0 > 0) == (dy0 > 0))) begin
      cls = steep ? mlr_pkg::SLOPE_STEEP_UP : mlr_pkg::SLOPE_SHALLOW_UP;
    end else begin
      cls = steep ? mlr_pkg::SLOPE_STEEP_DN : mlr_pkg::SLOPE_SHALLOW_DN;
    end

    swap = 1'b0;
    unique case (cls) inside
      mlr_pkg::SLOPE_SHALLOW_UP, mlr_pkg::SLOPE_SHALLOW_DN: swap = dx0 < 0;
      mlr_pkg::SLOPE_STEEP_UP:                              swap = dy0 < 0;
      mlr_pkg::SLOPE_STEEP_DN:                              swap = dy0 > 0;
      default: ;
    endcase

    dxe     = EB'(dx0);
    dye     = EB'(dy0);
    dx      = swap ? -dxe : dxe;
    dy      = swap ? -dye : dye;
    start_x = swap ? item.point_x : cur_x_r;
    start_y = swap ? item.point_y : cur_y_r;

    dec0  = '0;
    take0 = '0;
    keep0 = '0;
    stop0 = '0;
    unique case (cls)
      mlr_pkg::SLOPE_SHALLOW_UP: begin
        dec0  = dx - dy - dy;
        take0 = dx + dx - dy - dy;
        keep0 = -(dy + dy);
        stop0 = swap ? cur_x_r : item.point_x;
      end
      mlr_pkg::SLOPE_SHALLOW_DN: begin
        dec0  = -dx - dy - dy;
        take0 = -(dx + dx + dy + dy);
        keep0 = -(dy + dy);
        stop0 = swap ? cur_x_r : item.point_x;
      end
      mlr_pkg::SLOPE_STEEP_UP: begin
        dec0  = dx + dx - dy;
        take0 = dx + dx - dy - dy;
        keep0 = dx + dx;
        stop0 = swap ? cur_y_r : item.point_y;
      end
      mlr_pkg::SLOPE_STEEP_DN: begin
        dec0  = -(dx + dx) - dy;
        take0 = -(dx + dx + dy + dy);
        keep0 = -(dx + dx);
        stop0 = swap ? cur_y_r : item.point_y;
      end
      default: ;
    endcase
  end

  // Transaction decode
  always_comb begin
    result          = '0;
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    walk_x_nxt      = walk_x_r;
    walk_y_nxt      = walk_y_r;
    stop_major_nxt  = stop_major_r;
    decision_nxt    = decision_r;
    inc_take_nxt    = inc_take_r;
    inc_keep_nxt    = inc_keep_r;
    slope_class_nxt = slope_class_r;
    line_active_nxt = line_active_r;
    case (item.kind) inside
      mlr_pkg::KIND_STEP: begin
        if (line_active_r) begin
          result.pixel_valid = 1'b1;
          result.pixel_x     = walk_x_r;
          result.pixel_y     = walk_y_r;
          result.pixel_color = pen_color;
          walk_x_nxt         = step_x;
          walk_y_nxt         = step_y;
          decision_nxt       = step_dec;
          if (step_done) begin
            result.last_pixel = 1'b1;
            line_active_nxt   = 1'b0;
          end
        end
      end
      mlr_pkg::KIND_MOVE, mlr_pkg::KIND_LINE: begin
        if (line_active_r) begin
          // drop the transaction, flag it
          result.busy_reject = 1'b1;
        end else begin
          cur_x_nxt = item.point_x;
          cur_y_nxt = item.point_y;
          if (item.kind == mlr_pkg::KIND_LINE && !zero_len) begin
            walk_x_nxt      = start_x;
            walk_y_nxt      = start_y;
            stop_major_nxt  = stop0;
            decision_nxt    = dec0;
            inc_take_nxt    = take0;
            inc_keep_nxt    = keep0;
            slope_class_nxt = cls;
            line_active_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      walk_x_r      <= '0;
      walk_y_r      <= '0;
      stop_major_r  <= '0;
      decision_r    <= '0;
      inc_take_r    <= '0;
      inc_keep_r    <= '0;
      slope_class_r <= mlr_pkg::SLOPE_SHALLOW_UP;
      line_active_r <= 1'b0;
    end else if (fire) begin
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      walk_x_r      <= walk_x_nxt;
      walk_y_r      <= walk_y_nxt;
      stop_major_r  <= stop_major_nxt;
      decision_r    <= decision_nxt;
      inc_take_r    <= inc_take_nxt;
      inc_keep_r    <= inc_keep_nxt;
      slope_class_r <= slope_class_nxt;
      line_active_r <= line_active_nxt;
    end
  end

endmodule

[rtl/core/midpoint_line_rasterizer_core.sv]
// Top level of the midpoint line rasterizer: handshakes, pen color, result register.
// Depends on mlr_pkg and mlr_walker.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries move, line and step
//   transactions. A move sets the current point; a line walks between it and
//   the given point, which becomes current; each step of a walk returns one
//   pixel, with last_pixel set on the final one; a move or line during a walk
//   only flags busy_reject. Every input transaction yields exactly one result
//   transaction on out_valid/out_ready/out_data. cfg_we/cfg_wdata write the
//   pen color; write it only while no transaction is in flight.
// Timing:
//   An accepted transaction lands in the input register; the walker takes it when
//   the result register is free or draining; its result is registered to out_data.
//   One transaction per cycle while out_ready is high; the step is a single add
//   and compare on the decision variable, the line setup a short subtract chain.
// Reset (rst_n low, synchronous): both registers empty, walk idle, current
//   point at the origin, pen color white.
// Stall: while out_ready is low the result holds; one more transaction may be
//   taken into the input register, then in_ready drops.
module midpoint_line_rasterizer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mlr_pkg::mlr_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mlr_pkg::mlr_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [mlr_pkg::COLOR_BITS-1:0] cfg_wdata
);

  logic                           in_valid_r;
  mlr_pkg::mlr_in_t               in_data_r;
  logic                           out_valid_r;
  mlr_pkg::mlr_out_t              out_data_r;
  logic [mlr_pkg::COLOR_BITS-1:0] pen_color_r;
  mlr_pkg::mlr_out_t              result;
  logic                           fire;

  // process the held transaction when the result slot is free or draining
  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  mlr_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_data_r),
    .pen_color (pen_color_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pen_color_r <= mlr_pkg::PEN_COLOR_RST;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        pen_color_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/mlr_checker.sv]
// Port-level checks for the midpoint line rasterizer core, bound to the top level.
// Depends on mlr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mlr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input mlr_pkg::mlr_out_t out_data
);

  logic empty_clean;

  assign empty_clean = out_data.pixel_x == '0 && out_data.pixel_y == '0 &&
                       out_data.pixel_color == '0 && !out_data.last_pixel;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result transaction changed")
  `ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid && !out_data.pixel_valid, empty_clean, "result without pixel carries nonzero fields")
  `ASSERT_IMPLY(a_reject_nopix, clk, rst_n, out_valid && out_data.busy_reject, !out_data.pixel_valid, "rejected transaction carries a pixel")
  `ASSERT_IMPLY(a_last_pix, clk, rst_n, out_valid && out_data.last_pixel, out_data.pixel_valid, "last pixel flag without a pixel")
  `ASSERT_IMPLY(a_ready_stall, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled while output side is free")

endmodule

bind midpoint_line_rasterizer_core mlr_checker u_mlr_checker (.*);
